@@ hw/rtl/point_list_with_radius_count_macros.svh @@
// Assertion macros shared by the point list checks.
`ifndef POINT_LIST_WITH_RADIUS_COUNT_MACROS_SVH
`define POINT_LIST_WITH_RADIUS_COUNT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while in reset.
`define PLC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("point list check failed");

// Next-cycle implication, sampled on clk, quiet while in reset.
`define PLC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("point list check failed");

`endif

@@ hw/rtl/plc_pkg.sv @@
// Shared types, constants and codes of the point list block.
package plc_pkg;

    localparam int CAPACITY = 64;
    localparam int KIND_W   = 3;
    localparam int COORD_W  = 16;
    localparam int RADIUS_W = 17;
    localparam int STATUS_W = 2;
    localparam int TALLY_W  = 7;
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int SQ_W     = 2 * COORD_W - 1;
    localparam int RR_W     = 2 * COORD_W;
    localparam int GRP_SIZE = 8;
    localparam int GRP_W    = $clog2(GRP_SIZE + 1);
    localparam int NGRP     = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
    localparam int PAD_W    = NGRP * GRP_SIZE;

    typedef enum logic [KIND_W-1:0] {
        K_ADD    = 3'd0,
        K_POP    = 3'd1,
        K_CUT    = 3'd2,
        K_RADIUS = 3'd3,
        K_FIND   = 3'd4,
        K_LEN    = 3'd5
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_PUSH,
        SH_POP,
        SH_CUT
    } shift_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_EVAL,
        S_COUNT,
        S_SUM,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               valid;
    } entry_t;

    typedef struct packed {
        shift_op_t          op;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [RR_W-1:0]    rr;
        logic               rr_ok;
    } cell_ctl_t;

endpackage

@@ hw/rtl/plc_cmd_if.sv @@
// Command channel: one item per point list operation.
interface plc_cmd_if;
    import plc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic signed [COORD_W-1:0]  px;
    logic signed [COORD_W-1:0]  py;
    logic signed [RADIUS_W-1:0] radius;

    modport source (output valid, kind, px, py, radius, input ready);
    modport sink   (input valid, kind, px, py, radius, output ready);
endinterface

@@ hw/rtl/plc_rsp_if.sv @@
// Response channel: one item per completed operation.
interface plc_rsp_if;
    import plc_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TALLY_W-1:0]  tally;
    logic                found;

    modport source (output valid, status, tally, found, input ready);
    modport sink   (input valid, status, tally, found, output ready);
endinterface

@@ hw/rtl/plc_cell.sv @@
// One list slot: holds a point, matches it, squares it and shifts with its neighbours.
module plc_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  plc_pkg::cell_ctl_t ctl,
    input  plc_pkg::entry_t    prev_entry,
    input  plc_pkg::entry_t    next_entry,
    output plc_pkg::entry_t    entry,
    input  logic               seen_in,
    output logic               seen_out,
    output logic               hit
);
    import plc_pkg::*;

    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] y_reg, y_next;
    logic               valid_reg, valid_next;
    logic               match_reg, match_next;
    logic               hit_reg, hit_next;
    logic [SQ_W-1:0]    sqx_reg, sqy_reg;
    logic [COORD_W:0]   ax, ay;
    logic [2*COORD_W+1:0] sqx_full, sqy_full;
    logic [RR_W-1:0]    norm_sq;

    // Magnitudes and squares of the held point
    assign ax       = x_reg[COORD_W-1] ? ((COORD_W+1)'(0) - {1'b1, x_reg}) : {1'b0, x_reg};
    assign ay       = y_reg[COORD_W-1] ? ((COORD_W+1)'(0) - {1'b1, y_reg}) : {1'b0, y_reg};
    assign sqx_full = ax * ax;
    assign sqy_full = ay * ay;
    assign norm_sq  = RR_W'(sqx_reg) + RR_W'(sqy_reg);

    // Compare against the command point and the squared radius
    assign match_next = valid_reg && (x_reg == ctl.px) && (y_reg == ctl.py);
    assign hit_next   = valid_reg && ctl.rr_ok && (norm_sq <= ctl.rr);

    // Carry the first-match flag down the row
    assign seen_out = seen_in | match_reg;

    // Pick the next slot contents
    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        valid_next = valid_reg;
        case (ctl.op)
            SH_HOLD:
            begin
                x_next     = x_reg;
                y_next     = y_reg;
                valid_next = valid_reg;
            end
            SH_PUSH:
            begin
                x_next     = prev_entry.x;
                y_next     = prev_entry.y;
                valid_next = prev_entry.valid;
            end
            SH_POP:
            begin
                x_next     = next_entry.x;
                y_next     = next_entry.y;
                valid_next = next_entry.valid;
            end
            SH_CUT:
            begin
                if (seen_out)
                begin
                    x_next     = next_entry.x;
                    y_next     = next_entry.y;
                    valid_next = next_entry.valid;
                end
            end
            default:
            begin
                x_next     = x_reg;
                y_next     = y_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // Hold the point and the squares
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        sqx_reg <= sqx_full[SQ_W-1:0];
        sqy_reg <= sqy_full[SQ_W-1:0];
    end

    // Hold the slot flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
            hit_reg   <= hit_next;
        end
    end

    assign entry = '{x: x_reg, y: y_reg, valid: valid_reg};
    assign hit   = hit_reg;
endmodule

@@ hw/rtl/plc_tally.sv @@
// Two-stage registered count of the in-radius flags of all slots.
module plc_tally (
    input  logic                          clk,
    input  logic [plc_pkg::CAPACITY-1:0]  hits,
    output logic [plc_pkg::LEN_W-1:0]     total
);
    import plc_pkg::*;

    logic [PAD_W-1:0] padded;
    logic [GRP_W-1:0] grp_next [NGRP];
    logic [GRP_W-1:0] grp_reg  [NGRP];
    logic [LEN_W-1:0] total_next;
    logic [LEN_W-1:0] total_reg;

    assign padded = PAD_W'(hits);

    // Count each group of eight flags
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int b = 0; b < GRP_SIZE; b++)
            begin
                grp_next[g] = grp_next[g] + GRP_W'(padded[g*GRP_SIZE + b]);
            end
        end
    end

    // Add up the group counts
    always_comb
    begin
        total_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            total_next = total_next + LEN_W'(grp_reg[g]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_reg[g] <= grp_next[g];
        end
        total_reg <= total_next;
    end

    assign total = total_reg;
endmodule

@@ hw/rtl/point_list_with_radius_count.sv @@
// Top level of the point list: command sequencer, row of slot cells, count tree.
//
// Usage
//   cmd carries one operation per item: kind, px, py, radius. rsp returns
//   exactly one item per command: status, tally, found, in command order.
//   The list holds up to CAPACITY points newest first in a row of cells;
//   add and remove-front shift the whole row, remove-match only the slots
//   from the first match on. cmd.ready is high only while idle, so a new
//   command is taken only once the last result has gone into the output
//   register. The sequencer steps are: match in the cells, shift and radius
//   compare, then the two stages of the count tree, then the output load.
//   The result sits in an output register; if rsp.ready is low the
//   sequencer waits with the finished result and takes no new command until
//   the output register frees.
//   Reset (rst_n low, asynchronous) empties the list and drops any item in
//   flight; no clearing pass is needed.
module point_list_with_radius_count (
    input  logic      clk,
    input  logic      rst_n,
    plc_cmd_if.sink   cmd,
    plc_rsp_if.source rsp
);
    import plc_pkg::*;

    state_t              state_reg, state_next;
    logic [KIND_W-1:0]   kind_reg;
    logic [COORD_W-1:0]  px_reg, py_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [RR_W-1:0]     rr_reg, r_ext;
    logic                rr_ok_reg;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [TALLY_W-1:0]  res_tally_reg, res_tally_next;
    logic                res_found_reg, res_found_next;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [TALLY_W-1:0]  out_tally_reg;
    logic                out_found_reg;
    logic                out_free;
    logic                take_cmd;
    logic                load_out;
    shift_op_t           op_sel;
    cell_ctl_t           ctl;
    entry_t              cell_entry [CAPACITY];
    logic [CAPACITY:0]   seen;
    logic [CAPACITY-1:0] hits;
    logic [LEN_W-1:0]    hit_total;
    logic                full, empty;

    assign full     = (len_reg == LEN_W'(CAPACITY));
    assign empty    = (len_reg == '0);
    assign out_free = !out_valid_reg || rsp.ready;
    assign take_cmd = cmd.valid && cmd.ready;

    // Latch the command
    always_ff @(posedge clk)
    begin
        if (take_cmd)
        begin
            kind_reg   <= cmd.kind;
            px_reg     <= cmd.px;
            py_reg     <= cmd.py;
            radius_reg <= cmd.radius;
        end
    end

    // Square the radius; a negative radius counts nothing
    assign r_ext = RR_W'(radius_reg[RADIUS_W-2:0]);
    always_ff @(posedge clk)
    begin
        rr_reg    <= r_ext * r_ext;
        rr_ok_reg <= !radius_reg[RADIUS_W-1];
    end

    // Choose the row shift for the command
    always_comb
    begin
        op_sel = SH_HOLD;
        case (kind_reg)
            K_ADD:   op_sel = full  ? SH_HOLD : SH_PUSH;
            K_POP:   op_sel = empty ? SH_HOLD : SH_POP;
            K_CUT:   op_sel = SH_CUT;
            default: op_sel = SH_HOLD;
        endcase
    end

    assign ctl = '{
        op:    (state_reg == S_EVAL) ? op_sel : SH_HOLD,
        px:    px_reg,
        py:    py_reg,
        rr:    rr_reg,
        rr_ok: rr_ok_reg
    };

    // Row of slot cells
    assign seen[0] = 1'b0;
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t prev_e, next_e;
        if (i == 0)
        begin : g_front
            assign prev_e = '{x: px_reg, y: py_reg, valid: 1'b1};
        end
        else
        begin : g_mid_prev
            assign prev_e = cell_entry[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_back
            assign next_e = '{x: '0, y: '0, valid: 1'b0};
        end
        else
        begin : g_mid_next
            assign next_e = cell_entry[i+1];
        end

        plc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .entry      (cell_entry[i]),
            .seen_in    (seen[i]),
            .seen_out   (seen[i+1]),
            .hit        (hits[i])
        );
    end

    // Count of in-radius slots
    plc_tally u_tally (
        .clk   (clk),
        .hits  (hits),
        .total (hit_total)
    );

    // Work out the length and the non-count results at the shift step
    always_comb
    begin
        len_next        = len_reg;
        res_status_next = STAT_OK;
        res_tally_next  = '0;
        res_found_next  = 1'b0;
        case (kind_reg)
            K_ADD:
            begin
                if (full)
                    res_status_next = STAT_FULL;
                else
                    len_next = len_reg + LEN_W'(1);
            end
            K_POP:
            begin
                if (empty)
                    res_status_next = STAT_MISS;
                else
                    len_next = len_reg - LEN_W'(1);
            end
            K_CUT:
            begin
                if (seen[CAPACITY])
                    len_next = len_reg - LEN_W'(1);
                else
                    res_status_next = STAT_MISS;
            end
            K_FIND:
            begin
                if (seen[CAPACITY])
                    res_found_next = 1'b1;
                else
                    res_status_next = STAT_MISS;
            end
            K_LEN:   res_tally_next = TALLY_W'(len_reg);
            default: res_status_next = STAT_OK;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EVAL)
        begin
            res_status_reg <= res_status_next;
            res_tally_reg  <= res_tally_next;
            res_found_reg  <= res_found_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= '0;
        else if (state_reg == S_EVAL)
            len_reg <= len_next;
    end

    // Sequencer: next state and handshakes
    always_comb
    begin
        state_next = state_reg;
        cmd.ready  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                    state_next = S_MATCH;
            end
            S_MATCH: state_next = S_EVAL;
            S_EVAL:  state_next = S_COUNT;
            S_COUNT: state_next = S_SUM;
            S_SUM:   state_next = S_RESULT;
            S_RESULT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Output register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (kind_reg == K_RADIUS)
            begin
                out_status_reg <= (hit_total == '0) ? STAT_MISS : STAT_OK;
                out_tally_reg  <= TALLY_W'(hit_total);
                out_found_reg  <= 1'b0;
            end
            else
            begin
                out_status_reg <= res_status_reg;
                out_tally_reg  <= res_tally_reg;
                out_found_reg  <= res_found_reg;
            end
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.tally  = out_tally_reg;
    assign rsp.found  = out_found_reg;
endmodule

@@ hw/rtl/plc_checker.sv @@
// Port-level checks of the point list, bound to the top level.
`include "point_list_with_radius_count_macros.svh"

module plc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cmd_valid,
    input logic                         cmd_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [plc_pkg::STATUS_W-1:0] rsp_status,
    input logic [plc_pkg::TALLY_W-1:0]  rsp_tally,
    input logic                         rsp_found
);
    import plc_pkg::*;

    // One command at a time: no accept in the cycle after an accept
    `PLC_ASSERT_NEXT(a_one_in_flight, cmd_valid && cmd_ready, !cmd_ready)

    // A found point always reports ok
    `PLC_ASSERT_IMPL(a_found_ok, rsp_valid && rsp_found, rsp_status == STAT_OK)

    // A dropped add carries no tally and no match
    `PLC_ASSERT_IMPL(a_full_clean, rsp_valid && rsp_status == STAT_FULL,
                     rsp_tally == '0 && !rsp_found)

    // A stalled result holds
    `PLC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_status) && $stable(rsp_tally) && $stable(rsp_found))
endmodule

bind point_list_with_radius_count plc_checker u_plc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_tally  (rsp.tally),
    .rsp_found  (rsp.found)
);
